>>> hdl/polynomial_atan2_macros.svh
// assertion macros for the polynomial arctangent block
`ifndef POLYNOMIAL_ATAN2_MACROS_SVH
`define POLYNOMIAL_ATAN2_MACROS_SVH
`ifndef ASSERT_OFF
`define PA_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define PA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define PA_ASSERT_IMP(label, clk, rst_n, a, c)
`define PA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/patan_pkg.sv
// shared types and constants of the polynomial arctangent block
package patan_pkg;
	localparam int WORK_FRAC = 18;
	localparam int R_BITS = 17;
	localparam int T_BITS = 19;
	localparam int P_BITS = 20;
	localparam int ACC_BITS = 22;
	localparam logic signed [P_BITS-1:0] COEF_0 = -20'sd3534;
	localparam logic signed [P_BITS-1:0] COEF_1 = 20'sd15067;
	localparam logic signed [P_BITS-1:0] COEF_2 = -20'sd31782;
	localparam logic signed [P_BITS-1:0] COEF_3 = 20'sd51285;
	localparam logic signed [P_BITS-1:0] COEF_4 = -20'sd87293;
	localparam logic signed [P_BITS-1:0] COEF_5 = 20'sd262143;
	localparam logic signed [ACC_BITS-1:0] HALF_PI_Q = 22'sd411775;
	localparam logic signed [ACC_BITS-1:0] PI_Q = 22'sd823550;

	// octant flags that ride alongside the datapath
	typedef struct packed {
		logic swap;
		logic x_neg;
		logic y_neg;
		logic zero;
	} oct_t;
endpackage

>>> hdl/patan_if.sv
// valid/ready stream interface
interface patan_if #(parameter int W = 32) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/polynomial_atan2.sv
// top level of the pipelined polynomial arctangent
`include "polynomial_atan2_macros.svh"
// polynomial_atan2: four-quadrant arctangent of a signed (x, y) pair
// input channel in_ch carries {y_in, x_in}; output channel out_ch carries
// {undefined_flag, angle}, angle in radians with ANGLE_FRAC_BITS fraction bits
// one beat is accepted every cycle while the output side takes results
// stages: 1 magnitude stage, 17 divider stages (one quotient bit each),
// 1 squaring stage, 6 multiply stages (Horner plus final r product),
// 2 reflection/rounding stages
// throughput is one beat per cycle unless out_ch stalls, set by the fully pipelined divider
// the whole pipe advances together; when the receiver holds ready low with
// a result waiting in the output register, every stage freezes and in_ch
// ready drops, so nothing is lost or repeated
// reset clears all valid bits; payload registers are not reset
// both inputs zero: angle 0, undefined_flag set
module polynomial_atan2 #(
	parameter int INPUT_BITS = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input logic clk,
	input logic arst_n,
	patan_if.sink in_ch,
	patan_if.source out_ch
);
	import patan_pkg::*;

	localparam int MAG_BITS = INPUT_BITS;
	localparam int ANGLE_BITS = ANGLE_FRAC_BITS + 3;
	localparam int DIV_LAT = R_BITS;
	localparam int DEPTH = DIV_LAT + 10;
	localparam int SH = WORK_FRAC - ANGLE_FRAC_BITS;

	// single enable for the whole pipe
	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en = !vld_q[DEPTH-1] || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: magnitudes, ordering, octant flags
	logic signed [INPUT_BITS-1:0] x_i, y_i;
	logic [MAG_BITS-1:0] ax, ay;
	assign x_i = in_ch.data[INPUT_BITS-1:0];
	assign y_i = in_ch.data[2*INPUT_BITS-1:INPUT_BITS];
	assign ax = x_i[INPUT_BITS-1] ? MAG_BITS'(-x_i) : MAG_BITS'(x_i);
	assign ay = y_i[INPUT_BITS-1] ? MAG_BITS'(-y_i) : MAG_BITS'(y_i);

	logic [MAG_BITS-1:0] mn_s1, mx_s1;
	oct_t oct_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= (ax > ay) ? ax : ay;
			mn_s1 <= (ax > ay) ? ay : ax;
			oct_s1.swap <= ay > ax;
			oct_s1.x_neg <= x_i[INPUT_BITS-1];
			oct_s1.y_neg <= y_i[INPUT_BITS-1];
			oct_s1.zero <= (ax == '0) && (ay == '0);
		end
	end

	// divider; a zero divisor gives a junk ratio that the zero flag masks
	logic [R_BITS-1:0] r_div;
	patan_div #(.MAG_BITS(MAG_BITS)) u_div (
		.clk(clk), .en(en),
		.num(mn_s1), .den(mx_s1), .quo(r_div)
	);

	// octant flags delayed alongside the divider
	oct_t oct_d [DIV_LAT+1];
	assign oct_d[0] = oct_s1;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_od
		always_ff @(posedge clk) if (en) oct_d[k+1] <= oct_d[k];
	end

	// squaring stage
	logic [R_BITS-1:0] r_sq;
	logic [T_BITS-1:0] t_sq;
	oct_t oct_sq;
	logic [2*R_BITS-1:0] rr;
	assign rr = r_div * r_div;
	always_ff @(posedge clk) begin
		if (en) begin
			r_sq <= r_div;
			t_sq <= T_BITS'(rr >> 14);
			oct_sq <= oct_d[DIV_LAT];
		end
	end

	// horner chain: five steps on t, one step on r<<2
	localparam int MB = P_BITS + T_BITS + 1;
	logic signed [P_BITS-1:0] coef_k [5];
	assign coef_k[0] = COEF_1;
	assign coef_k[1] = COEF_2;
	assign coef_k[2] = COEF_3;
	assign coef_k[3] = COEF_4;
	assign coef_k[4] = COEF_5;

	logic signed [P_BITS-1:0] p_h [6];
	logic [R_BITS-1:0] r_h [6];
	logic [T_BITS-1:0] t_h [6];
	oct_t oct_h [6];
	assign p_h[0] = COEF_0;
	assign r_h[0] = r_sq;
	assign t_h[0] = t_sq;
	assign oct_h[0] = oct_sq;
	for (genvar k = 0; k < 5; k++) begin : g_hn
		logic signed [MB-1:0] prod;
		assign prod = MB'(p_h[k]) * $signed({1'b0, t_h[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				p_h[k+1] <= P_BITS'(prod >>> WORK_FRAC) + coef_k[k];
				r_h[k+1] <= r_h[k];
				t_h[k+1] <= t_h[k];
				oct_h[k+1] <= oct_h[k];
			end
		end
	end

	localparam int MR = P_BITS + R_BITS + 3;
	logic signed [MR-1:0] prod_r;
	logic signed [ACC_BITS-1:0] acc_s1;
	oct_t oct_a1;
	assign prod_r = MR'(p_h[5]) * $signed({1'b0, r_h[5], 2'b00});
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1 <= ACC_BITS'(prod_r >>> WORK_FRAC);
			oct_a1 <= oct_h[5];
		end
	end

	// reflections
	logic signed [ACC_BITS-1:0] f1, f2, f3;
	assign f1 = oct_a1.swap ? HALF_PI_Q - acc_s1 : acc_s1;
	assign f2 = oct_a1.x_neg ? PI_Q - f1 : f1;
	assign f3 = oct_a1.y_neg ? -f2 : f2;
	logic signed [ACC_BITS-1:0] acc_s2;
	logic zero_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= f3;
			zero_s2 <= oct_a1.zero;
		end
	end

	// rounding half up to output format
	localparam int RW = ACC_BITS + 16;
	logic signed [RW-1:0] accw, rnd;
	assign accw = RW'(acc_s2);
	always_comb begin
		if (SH > 0) rnd = (accw + (RW'(1) <<< (SH - 1))) >>> SH;
		else rnd = accw <<< (-SH);
	end
	logic [ANGLE_BITS-1:0] angle_s3;
	logic flag_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			angle_s3 <= zero_s2 ? '0 : ANGLE_BITS'(rnd);
			flag_s3 <= zero_s2;
		end
	end

	// valid shift line matching the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
		end
	end

	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.data = {flag_s3, angle_s3};

	`PA_ASSERT_IMP(a_stall_ready, clk, arst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
	`PA_ASSERT_IMP(a_flag_zero, clk, arst_n, out_ch.valid && out_ch.data[ANGLE_BITS], out_ch.data[ANGLE_BITS-1:0] == '0)
	`PA_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
endmodule

>>> hdl/patan_div.sv
// pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per stage
module patan_div #(
	parameter int MAG_BITS = 17
) (
	input logic clk,
	input logic en,
	input logic [MAG_BITS-1:0] num,
	input logic [MAG_BITS-1:0] den,
	output logic [patan_pkg::R_BITS-1:0] quo
);
	import patan_pkg::*;

	// remainder stays below den, quotient bit count is R_BITS
	logic [MAG_BITS:0] rem_s [R_BITS+1];
	logic [MAG_BITS-1:0] den_s [R_BITS+1];
	logic [R_BITS-1:0] q_s [R_BITS+1];

	assign rem_s[0] = {1'b0, num};
	assign den_s[0] = den;
	assign q_s[0] = '0;

	// first stage: integer bit (num <= den), then 16 fraction bits
	for (genvar k = 0; k < R_BITS; k++) begin : g_st
		logic [MAG_BITS+1:0] shifted;
		logic ge;
		logic [MAG_BITS:0] nrem;
		always_comb begin
			shifted = (k == 0) ? {1'b0, rem_s[k]} : {rem_s[k], 1'b0};
			ge = shifted >= {2'b00, den_s[k]};
			nrem = ge ? MAG_BITS'(shifted - {2'b00, den_s[k]}) + (MAG_BITS+1)'(0)
				: shifted[MAG_BITS:0];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= nrem;
				den_s[k+1] <= den_s[k];
				q_s[k+1] <= {q_s[k][R_BITS-2:0], ge};
			end
		end
	end
	assign quo = q_s[R_BITS];
endmodule

>>> tb/tb_polynomial_atan2_chk.sv
// checker: predicts the arctangent of each input beat and compares output beats
module tb_polynomial_atan2_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [31:0] in_data,
	input logic out_valid,
	input logic out_ready,
	input logic [16:0] out_data,
	output int fail_count,
	output int pending,
	output int seen
);
	// flag sits above the angle, as on the output beat
	typedef struct packed {
		logic undef;
		logic [15:0] angle;
	} angle_res_t;

	angle_res_t angle_q[$];

	function automatic longint floor_div(longint v, int s);
		longint m;
		if (v >= 0) begin
			return v >>> s;
		end
		m = -v;
		return -((m + ((64'sd1 <<< s) - 1)) >>> s);
	endfunction

	function automatic angle_res_t atan_predict(logic signed [15:0] xv, logic signed [15:0] yv);
		angle_res_t res;
		longint ax, ay, mx, mn, r, t, p, acc;
		longint coef[6];
		coef = '{-3534, 15067, -31782, 51285, -87293, 262143};
		ax = (xv < 0) ? -longint'(xv) : longint'(xv);
		ay = (yv < 0) ? -longint'(yv) : longint'(yv);
		if (ax == 0 && ay == 0) begin
			res.angle = '0;
			res.undef = 1'b1;
			return res;
		end
		mx = (ax > ay) ? ax : ay;
		mn = (ax > ay) ? ay : ax;
		r = (mn << 16) / mx;
		t = (r * r) >> 14;
		p = coef[0];
		for (int i = 1; i < 6; i++) begin
			p = floor_div(p * t, 18) + coef[i];
		end
		acc = floor_div(p * (r << 2), 18);
		if (ay > ax) acc = 411775 - acc;
		if (xv < 0) acc = 823550 - acc;
		if (yv < 0) acc = -acc;
		acc = floor_div(acc + 16, 5);
		res.angle = acc[15:0];
		res.undef = 1'b0;
		return res;
	endfunction

	angle_res_t got, want;

	initial begin
		fail_count = 0;
		seen = 0;
	end
	assign pending = angle_q.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				angle_q.push_back(atan_predict(in_data[15:0], in_data[31:16]));
			end
			if (out_valid && out_ready) begin
				got = out_data;
				seen <= seen + 1;
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = angle_q.pop_front();
					if (got.angle !== want.angle || got.undef !== want.undef) begin
						$display("%0t: mismatch expected angle %0d flag %b, actual angle %0d flag %b",
							$time, $signed(want.angle), want.undef,
							$signed(got.angle), got.undef);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> tb/tb_polynomial_atan2.sv
// testbench top: stimulus, back-pressure and verdict for the arctangent block
module tb_polynomial_atan2;
	logic clk;
	logic arst_n;
	int fail_count, pending, seen;
	bit quiet;  // no idling in the closing stretch

	patan_if #(.W(32)) in_ch (.clk(clk));
	patan_if #(.W(17)) out_ch (.clk(clk));

	polynomial_atan2 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	tb_polynomial_atan2_chk u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.fail_count(fail_count),
		.pending(pending),
		.seen(seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random stall bursts, changed on the falling edge
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 2);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// send one beat; valid is held high across back-to-back beats
	task automatic send_pair(logic [15:0] xv, logic [15:0] yv);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {yv, xv};
		// wait for the accepting edge, then step to the next falling edge
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// pick a component: half the time full range, otherwise near the edges or small
	function automatic logic [15:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 16'(16'h8000 + $urandom_range(0, 3));
			1: return 16'(16'h7fff - $urandom_range(0, 3));
			2: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	logic [15:0] mag;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero pair, axes, diagonals, extreme magnitudes
		send_pair(16'd0, 16'd0);
		send_pair(16'd1, 16'd0);
		send_pair(16'hffff, 16'd0);          // y zero, x negative: +pi
		send_pair(16'h8000, 16'd0);
		send_pair(16'd0, 16'h7fff);
		send_pair(16'd0, 16'h8000);
		send_pair(16'h7fff, 16'h7fff);       // equal magnitudes
		send_pair(16'h8000, 16'h8000);
		send_pair(16'h8000, 16'h7fff);
		send_pair(16'h7fff, 16'h8000);
		send_pair(16'hffff, 16'hffff);
		send_pair(16'd1, 16'hffff);
		send_pair(16'hffff, 16'd1);
		send_pair(16'h7fff, 16'd1);
		send_pair(16'd1, 16'h7fff);
		send_pair(16'h8000, 16'hffff);
		send_pair(16'h5555, 16'haaaa);
		send_pair(16'haaaa, 16'h5555);

		// hold off until every expected result is back
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);

		for (int i = 0; i < 500; i++) begin
			if (i == 420) quiet = 1'b1;
			if ($urandom_range(0, 7) == 0) begin
				// equal magnitudes in random quadrants
				mag = 16'($urandom_range(0, 32767));
				send_pair($urandom_range(0, 1) ? mag : -mag, $urandom_range(0, 1) ? mag : -mag);
			end else begin
				send_pair(pick_comp(), pick_comp());
			end
		end
		in_ch.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("covered %0d angle beats: axes, diagonals, zero pair and full-range pairs", seen);
		$display("with random stalls on both channels and a drained pause mid-run");
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
